// File: rtl/core/sra_pkg.sv
// selective-repeat arq package: field types, codes, command and status structs
`timescale 1ns / 1ps

package sra_pkg;

  localparam int SEQ_BITS = 3;
  localparam int NR_BUFS  = 4;
  localparam int PKT_W    = 32;
  localparam int IDX_W    = $clog2(NR_BUFS);
  localparam int CNT_W    = $clog2(NR_BUFS + 1);

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [PKT_W-1:0]    pkt_t;

  typedef enum logic [2:0] {
    OP_NEW_PKT     = 3'd0,
    OP_FRAME       = 3'd1,
    OP_CKSUM_ERR   = 3'd2,
    OP_TIMEOUT     = 3'd3,
    OP_ACK_TIMEOUT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ACT_SEND         = 2'd0,
    ACT_DELIVER      = 2'd1,
    ACT_STOP_TIMER   = 2'd2,
    ACT_STATUS_TIMER = 2'd3
  } action_e;

  typedef struct packed {
    logic [2:0] op;
    pkt_t       new_packet;
    logic [1:0] rx_kind;
    seq_t       rx_seq;
    seq_t       rx_ack;
    pkt_t       rx_payload;
    seq_t       expired_seq;
  } in_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] tx_kind;
    seq_t       tx_seq;
    seq_t       tx_ack;
    pkt_t       payload;
    logic       ack_tmr_start;
    logic       net_enable;
    logic       last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic send_new;
    logic send_nak;
    logic ack_timer;
    logic send_retx;
    logic send_ack;
    logic store_rx;
    logic deliver;
    logic resend;
    logic stop;
    logic status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] rx_kind;
    logic       win_full;
    logic       nak_ok;
    logic       seq_is_low;
    logic       rx_fresh;
    logic       deliver_rdy;
    logic       resend_ok;
    logic       stop_ok;
  } stat_t;

  // a <= b < c in circular order
  function automatic logic in_window(seq_t a, seq_t b, seq_t c);
    in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                ((b < c) && (c < a));
  endfunction

endpackage

// File: rtl/core/selective_repeat_arq_top.sv
// selective-repeat arq engine top level
//
//   channel   direction  transfer when            payload
//   event     in         start && !busy           item_i   (in_t)
//   result    out        res_strobe_o (1 cycle)   result_o (res_t)
//
// the controller emits at most one result per cycle, so the delivery loop
// and the ack loop (up to NR_BUFS steps each) set how long an event keeps
// the engine busy.
// results appear in the cycle after the step that makes them; the status item
// (last set) shows in the first cycle that busy is low again.
// reset clears the windows, counters and arrival map; the packet stores keep
// whatever they hold. the receiver cannot stall; start is ignored while busy.
`timescale 1ns / 1ps

module selective_repeat_arq_top import sra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic res_strobe_o,
  output res_t result_o
);

  // command and status between the controller and the datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: one state per step of the event, one result per step at most
  sra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // window state, packet stores and the registered result
  sra_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_valid_o(res_strobe_o),
    .res_o      (result_o)
  );

endmodule

// File: rtl/core/sra_datapath.sv
// selective-repeat arq datapath: window registers, stores, result register
`timescale 1ns / 1ps

module sra_datapath import sra_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  in_t   item_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output logic  res_valid_o,
  output res_t  res_o
);

  in_t              item_q;
  seq_t             send_low_q, send_next_q, recv_low_q, recv_high_q;
  logic [CNT_W-1:0] outstanding_q;
  logic             nak_allowed_q;
  logic [NR_BUFS-1:0] arrived_q;
  pkt_t             send_store_q [NR_BUFS];
  pkt_t             recv_store_q [NR_BUFS];
  logic             res_valid_q;
  res_t             res_q, res_d;

  seq_t             nr;
  seq_t             ack_field;
  logic [IDX_W-1:0] rx_idx, low_idx, next_idx, nr_idx, exp_idx, slow_idx;
  logic             win_full;

  assign nr        = item_q.rx_ack + seq_t'(1);
  assign ack_field = recv_low_q - seq_t'(1);
  assign rx_idx    = item_q.rx_seq[IDX_W-1:0];
  assign low_idx   = recv_low_q[IDX_W-1:0];
  assign next_idx  = send_next_q[IDX_W-1:0];
  assign nr_idx    = nr[IDX_W-1:0];
  assign exp_idx   = item_q.expired_seq[IDX_W-1:0];
  assign slow_idx  = send_low_q[IDX_W-1:0];
  assign win_full  = outstanding_q >= CNT_W'(NR_BUFS);

  always_comb begin
    stat_o.op          = item_q.op;
    stat_o.rx_kind     = item_q.rx_kind;
    stat_o.win_full    = win_full;
    stat_o.nak_ok      = nak_allowed_q;
    stat_o.seq_is_low  = item_q.rx_seq == recv_low_q;
    stat_o.rx_fresh    = in_window(recv_low_q, item_q.rx_seq, recv_high_q) &&
                         !arrived_q[rx_idx];
    stat_o.deliver_rdy = arrived_q[low_idx];
    stat_o.resend_ok   = (item_q.rx_kind == KIND_NAK) &&
                         in_window(send_low_q, nr, send_next_q);
    stat_o.stop_ok     = (outstanding_q != '0) &&
                         in_window(send_low_q, item_q.rx_ack, send_next_q);
  end

  // result item for this cycle's command
  always_comb begin
    res_d = '0;
    if (cmd_i.send_new) begin
      res_d.action  = ACT_SEND;
      res_d.tx_kind = KIND_DATA;
      res_d.tx_seq  = send_next_q;
      res_d.tx_ack  = ack_field;
      res_d.payload = item_q.new_packet;
    end else if (cmd_i.send_nak) begin
      res_d.action  = ACT_SEND;
      res_d.tx_kind = KIND_NAK;
      res_d.tx_ack  = ack_field;
    end else if (cmd_i.ack_timer) begin
      res_d.action        = ACT_STATUS_TIMER;
      res_d.ack_tmr_start = 1'b1;
    end else if (cmd_i.send_retx) begin
      res_d.action  = ACT_SEND;
      res_d.tx_kind = KIND_DATA;
      res_d.tx_seq  = item_q.expired_seq;
      res_d.tx_ack  = ack_field;
      res_d.payload = send_store_q[exp_idx];
    end else if (cmd_i.send_ack) begin
      res_d.action  = ACT_SEND;
      res_d.tx_kind = KIND_ACK;
      res_d.tx_ack  = ack_field;
    end else if (cmd_i.deliver) begin
      res_d.action        = ACT_DELIVER;
      res_d.payload       = recv_store_q[low_idx];
      res_d.ack_tmr_start = 1'b1;
    end else if (cmd_i.resend) begin
      res_d.action  = ACT_SEND;
      res_d.tx_kind = KIND_DATA;
      res_d.tx_seq  = nr;
      res_d.tx_ack  = ack_field;
      res_d.payload = send_store_q[nr_idx];
    end else if (cmd_i.stop) begin
      res_d.action = ACT_STOP_TIMER;
      res_d.tx_seq = seq_t'(slow_idx);
    end else if (cmd_i.status) begin
      res_d.action     = ACT_STATUS_TIMER;
      res_d.net_enable = !win_full;
      res_d.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_low_q    <= '0;
      send_next_q   <= '0;
      recv_low_q    <= '0;
      recv_high_q   <= seq_t'(NR_BUFS);
      outstanding_q <= '0;
      nak_allowed_q <= 1'b1;
      arrived_q     <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.send_new | cmd_i.send_nak | cmd_i.ack_timer |
                     cmd_i.send_retx | cmd_i.send_ack | cmd_i.deliver |
                     cmd_i.resend | cmd_i.stop | cmd_i.status;
      if (cmd_i.send_new) begin
        outstanding_q <= outstanding_q + CNT_W'(1);
        send_next_q   <= send_next_q + seq_t'(1);
      end
      if (cmd_i.send_nak) begin
        nak_allowed_q <= 1'b0;
      end
      if (cmd_i.store_rx) begin
        arrived_q[rx_idx] <= 1'b1;
      end
      if (cmd_i.deliver) begin
        nak_allowed_q      <= 1'b1;
        arrived_q[low_idx] <= 1'b0;
        recv_low_q         <= recv_low_q + seq_t'(1);
        recv_high_q        <= recv_high_q + seq_t'(1);
      end
      if (cmd_i.stop) begin
        outstanding_q <= outstanding_q - CNT_W'(1);
        send_low_q    <= send_low_q + seq_t'(1);
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.send_new) begin
      send_store_q[next_idx] <= item_q.new_packet;
    end
    if (cmd_i.store_rx) begin
      recv_store_q[rx_idx] <= item_q.rx_payload;
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/core/sra_ctrl.sv
// selective-repeat arq controller: event sequencing state machine
`timescale 1ns / 1ps

module sra_ctrl import sra_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_ACCEPT,
    S_DELIVER,
    S_RESEND,
    S_STOP,
    S_STATUS
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_FIRST;
        end
      end
      S_FIRST: begin
        state_d = S_STATUS;
        case (stat_i.op)
          OP_NEW_PKT: begin
            cmd_o.send_new = !stat_i.win_full;
          end
          OP_FRAME: begin
            if (stat_i.rx_kind == KIND_DATA) begin
              if (!stat_i.seq_is_low && stat_i.nak_ok) begin
                cmd_o.send_nak = 1'b1;
              end else begin
                cmd_o.ack_timer = 1'b1;
              end
              state_d = S_ACCEPT;
            end else begin
              state_d = S_RESEND;
            end
          end
          OP_CKSUM_ERR: begin
            cmd_o.send_nak = stat_i.nak_ok;
          end
          OP_TIMEOUT: begin
            cmd_o.send_retx = 1'b1;
          end
          OP_ACK_TIMEOUT: begin
            cmd_o.send_ack = 1'b1;
          end
          default: begin
            state_d = S_STATUS;
          end
        endcase
      end
      S_ACCEPT: begin
        if (stat_i.rx_fresh) begin
          cmd_o.store_rx = 1'b1;
          state_d        = S_DELIVER;
        end else begin
          state_d = S_RESEND;
        end
      end
      S_DELIVER: begin
        if (stat_i.deliver_rdy) begin
          cmd_o.deliver = 1'b1;
        end else begin
          state_d = S_RESEND;
        end
      end
      S_RESEND: begin
        cmd_o.resend = stat_i.resend_ok;
        state_d      = S_STOP;
      end
      S_STOP: begin
        if (stat_i.stop_ok) begin
          cmd_o.stop = 1'b1;
        end else begin
          state_d = S_STATUS;
        end
      end
      S_STATUS: begin
        cmd_o.status = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

// File: rtl/core/sra_checker.sv
// selective-repeat arq port checker and its bind to the top level
`timescale 1ns / 1ps

module sra_checker import sra_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input logic res_strobe_i,
  input res_t result_i
);

  // the status item closes an event, so the engine is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i && result_i.last |-> !busy_i)
    else $error("status shown while still busy");

  // an accepted event keeps the engine busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("not busy after event transfer");

  // nothing is produced in the cycle right after an event transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> !res_strobe_i)
    else $error("result right after event transfer");

  // status items carry the status action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i && result_i.last |-> result_i.action == ACT_STATUS_TIMER)
    else $error("last item is not a status item");

  // net enable is only reported on the status item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_i && !result_i.last |-> !result_i.net_enable)
    else $error("net enable outside status item");

endmodule

bind selective_repeat_arq_top sra_checker u_sra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start),
  .busy_i      (busy),
  .res_strobe_i(res_strobe_o),
  .result_i    (result_o)
);

// File: tb/arq_checker.sv
// result checker for the selective-repeat arq engine: predicts each event and compares its results
`timescale 1ns / 1ps

module arq_checker import sra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  in_t  item_i,
  input  logic res_strobe_i,
  input  res_t result_i,
  output int   fail_count_o,
  output int   pending_o
);

  // predicted protocol state
  seq_t snd_base, snd_next, rcv_base, rcv_top;
  int   in_flight;
  logic nak_ok;
  logic got_map [NR_BUFS];
  pkt_t tx_buf [NR_BUFS];
  pkt_t rx_buf [NR_BUFS];

  res_t expected_results [$];
  res_t want;
  int   fails = 0;

  // lo <= x < hi going around the sequence space
  function automatic logic seq_between(seq_t lo, seq_t x, seq_t hi);
    seq_t dx, dh;
    dx = x - lo;
    dh = hi - lo;
    return dx < dh;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("act=%0d kind=%0d seq=%0d ack=%0d pay=%h sat=%b ne=%b last=%b",
                     r.action, r.tx_kind, r.tx_seq, r.tx_ack, r.payload,
                     r.ack_tmr_start, r.net_enable, r.last);
  endfunction

  task automatic note_fail(string want_txt, res_t got);
    fails++;
    if (fails <= 10)
      $display("%0t ns: result mismatch\n  expected %s\n  actual   %s",
               $time, want_txt, show(got));
  endtask

  task automatic push_item(action_e act, seq_t sq, pkt_t pay, logic sat, logic ne,
                           logic lst);
    res_t r;
    r = '0;
    r.action        = act;
    r.tx_seq        = sq;
    r.payload       = pay;
    r.ack_tmr_start = sat;
    r.net_enable    = ne;
    r.last          = lst;
    expected_results.push_back(r);
  endtask

  // every outgoing frame carries the receiver low edge minus one as its ack
  task automatic push_frame(kind_e kind, seq_t nr);
    res_t r;
    r = '0;
    r.action  = ACT_SEND;
    r.tx_kind = kind;
    r.tx_seq  = nr;
    r.tx_ack  = rcv_base - 3'd1;
    if (kind == KIND_DATA)
      r.payload = tx_buf[nr % NR_BUFS];
    if (kind == KIND_NAK)
      nak_ok = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic predict_event(in_t ev);
    seq_t nr;
    case (ev.op)
      OP_NEW_PKT: begin
        if (in_flight < NR_BUFS) begin
          in_flight++;
          tx_buf[snd_next % NR_BUFS] = ev.new_packet;
          push_frame(KIND_DATA, snd_next);
          snd_next = snd_next + 3'd1;
        end
      end
      OP_FRAME: begin
        if (ev.rx_kind == KIND_DATA) begin
          if (ev.rx_seq != rcv_base && nak_ok)
            push_frame(KIND_NAK, '0);
          else
            push_item(ACT_STATUS_TIMER, '0, '0, 1'b1, 1'b0, 1'b0);
          if (seq_between(rcv_base, ev.rx_seq, rcv_top) &&
              !got_map[ev.rx_seq % NR_BUFS]) begin
            got_map[ev.rx_seq % NR_BUFS] = 1'b1;
            rx_buf[ev.rx_seq % NR_BUFS]  = ev.rx_payload;
            while (got_map[rcv_base % NR_BUFS]) begin
              push_item(ACT_DELIVER, '0, rx_buf[rcv_base % NR_BUFS], 1'b1, 1'b0, 1'b0);
              nak_ok = 1'b1;
              got_map[rcv_base % NR_BUFS] = 1'b0;
              rcv_base = rcv_base + 3'd1;
              rcv_top  = rcv_top + 3'd1;
            end
          end
        end
        nr = ev.rx_ack + 3'd1;
        if (ev.rx_kind == KIND_NAK && seq_between(snd_base, nr, snd_next))
          push_frame(KIND_DATA, nr);
        while (in_flight != 0 && seq_between(snd_base, ev.rx_ack, snd_next)) begin
          in_flight--;
          push_item(ACT_STOP_TIMER, seq_t'(snd_base % NR_BUFS), '0, 1'b0, 1'b0, 1'b0);
          snd_base = snd_base + 3'd1;
        end
      end
      OP_CKSUM_ERR: begin
        if (nak_ok)
          push_frame(KIND_NAK, '0);
      end
      OP_TIMEOUT:     push_frame(KIND_DATA, ev.expired_seq);
      OP_ACK_TIMEOUT: push_frame(KIND_ACK, '0);
      default: ;
    endcase
    push_item(ACT_STATUS_TIMER, '0, '0, 1'b0, in_flight < NR_BUFS, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snd_base  = '0;
      snd_next  = '0;
      rcv_base  = '0;
      rcv_top   = seq_t'(NR_BUFS);
      in_flight = 0;
      nak_ok    = 1'b1;
      for (int i = 0; i < NR_BUFS; i++)
        got_map[i] = 1'b0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // a result leaving this edge is older than an event entering it
      if (res_strobe_i) begin
        if (expected_results.size() == 0) begin
          note_fail("nothing", result_i);
        end else begin
          want = expected_results.pop_front();
          if (result_i !== want)
            note_fail(show(want), result_i);
        end
      end
      if (start_i && !busy_i)
        predict_event(item_i);
      pending_o    <= expected_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: tb/testbench.sv
// testbench top: clock, reset, event stimulus and verdict for the selective-repeat arq engine
`timescale 1ns / 1ps

module testbench;
  import sra_pkg::*;

  // random events that do real work (not counting ignored ones)
  localparam int N_EVENTS = 85;

  // event and frame codes the package leaves unnamed
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  in_t  item_i = '0;
  logic res_strobe_o;
  res_t result_o;
  int   fail_count;
  int   pending;

  // our own view of the sender window, kept only to shape the stimulus:
  // which acks are plausible and which send slots hold a packet
  seq_t               tx_low       = '0;
  seq_t               tx_next      = '0;
  logic [NR_BUFS-1:0] slot_written = '0;

  // the far end sends its data frames in bursts of one window, shuffled
  seq_t peer_base = '0;
  int   burst_order [NR_BUFS];
  int   burst_pos   = 0;

  int calm_left = 0;  // transfers left in a back-to-back stretch
  int useful    = 0;  // transfers the block actually acted on

  always #1 clk_i = ~clk_i;

  selective_repeat_arq_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_strobe_o(res_strobe_o),
    .result_o    (result_o)
  );

  arq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item_i),
    .res_strobe_i(res_strobe_o),
    .result_i    (result_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // every field random; callers overwrite the ones the event uses, so the
  // unused fields still toggle all their bits
  function automatic in_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  // an ack somewhere from "nothing new" up to the newest frame in flight
  function automatic seq_t fair_ack();
    seq_t in_air;
    in_air = tx_next - tx_low;
    return seq_t'(tx_low - 1 + $urandom_range(0, in_air));
  endfunction

  task automatic shuffle_burst();
    int j, t;
    for (int i = 0; i < NR_BUFS; i++)
      burst_order[i] = i;
    // half the bursts arrive in order, the rest permuted
    if ($urandom_range(0, 1)) begin
      for (int i = NR_BUFS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = burst_order[i];
        burst_order[i] = burst_order[j];
        burst_order[j] = t;
      end
    end
  endtask

  // one transfer: hold start until an edge sees busy low, then idle for the gap drawn, if any
  task automatic issue_event(in_t ev);
    seq_t in_air, d_ack;
    int   gap, r;
    start  <= 1'b1;
    item_i <= ev;
    do @(posedge clk_i); while (busy !== 1'b0);

    // follow the sender window; a full window swallows new packets
    in_air = tx_next - tx_low;
    if (ev.op == OP_NEW_PKT) begin
      if (in_air < NR_BUFS) begin
        slot_written[tx_next % NR_BUFS] = 1'b1;
        tx_next = tx_next + 3'd1;
        useful++;
      end
    end else if (ev.op == OP_FRAME) begin
      d_ack = ev.rx_ack - tx_low;
      if (d_ack < in_air)
        tx_low = ev.rx_ack + 3'd1;
      useful++;
    end else if (ev.op < OP_RSVD_LO) begin
      useful++;
    end

    // short gaps or none, a few long ones, and stretches with none at all
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 19);
      if (r == 0)
        calm_left = $urandom_range(6, 20);
      else if (r < 3)
        gap = $urandom_range(8, 40);
      else if (r < 12)
        gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_pkt(pkt_t pkt);
    in_t ev;
    ev = noise_item();
    ev.op = OP_NEW_PKT;
    ev.new_packet = pkt;
    issue_event(ev);
  endtask

  task automatic send_rx_frame(logic [1:0] kind, seq_t sq, seq_t ack, pkt_t pay);
    in_t ev;
    ev = noise_item();
    ev.op = OP_FRAME;
    ev.rx_kind = kind;
    ev.rx_seq = sq;
    ev.rx_ack = ack;
    ev.rx_payload = pay;
    issue_event(ev);
  endtask

  task automatic send_timeout(seq_t sq);
    in_t ev;
    ev = noise_item();
    ev.op = OP_TIMEOUT;
    ev.expired_seq = sq;
    issue_event(ev);
  endtask

  // events with no fields of their own: checksum error, ack timeout, reserved
  task automatic send_op(logic [2:0] op);
    in_t ev;
    ev = noise_item();
    ev.op = op;
    issue_event(ev);
  endtask

  initial begin
    int   r;
    seq_t sq;
    seq_t in_air;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // fill the send window with extreme packets, then overflow it
    send_pkt('0);
    send_pkt('1);
    send_pkt(32'hA5A5_5A5A);
    send_pkt(32'h1234_5678);
    send_pkt(32'hDEAD_BEEF);           // window full: ignored
    // retransmit timeouts, one on the top sequence number sharing slot 3
    send_timeout(3'd1);
    send_timeout(3'd7);
    send_op(OP_ACK_TIMEOUT);
    // first checksum error sends a nak, the second may not
    send_op(OP_CKSUM_ERR);
    send_op(OP_CKSUM_ERR);
    // out-of-order data while a nak is already out, then the gap fills
    // and both packets go up; the piggybacked ack frees frames 0 and 1
    send_rx_frame(KIND_DATA, 3'd1, 3'd7, '1);
    send_rx_frame(KIND_DATA, 3'd0, 3'd1, '0);
    // nak for frame 2 makes it go out again
    send_rx_frame(KIND_NAK, 3'd0, 3'd1, $urandom);
    // plain ack frees the rest of the window
    send_rx_frame(KIND_ACK, 3'd0, 3'd3, $urandom);
    // unknown frame kind: only its ack counts, here against an empty window
    send_rx_frame(KIND_RSVD, 3'd7, 3'd0, $urandom);
    // unknown events
    for (int k = 0; k < 3; k++)
      send_op(OP_RSVD_LO + 3'(k));
    // out of order with naks allowed again, then outside the window,
    // then the missing frame releases two packets
    send_rx_frame(KIND_DATA, 3'd3, 3'd3, 32'h0F0F_0F0F);
    send_rx_frame(KIND_DATA, 3'd6, 3'd3, 32'hF0F0_F0F0);
    send_rx_frame(KIND_DATA, 3'd2, 3'd3, 32'h8000_0001);
    send_pkt($urandom);

    // ---- random part ----
    // the directed part leaves the receive window starting at 4
    peer_base = seq_t'(NR_BUFS);
    burst_pos = 0;
    shuffle_burst();
    useful = 0;
    while (useful < N_EVENTS) begin
      r = $urandom_range(0, 99);
      in_air = tx_next - tx_low;
      if (r < 28) begin
        // new packets; with the window full, usually ack instead so that
        // few transfers are wasted
        if (in_air >= NR_BUFS && $urandom_range(0, 4) != 0)
          send_rx_frame(KIND_ACK, seq_t'($urandom), fair_ack(), $urandom);
        else
          send_pkt($urandom);
      end else if (r < 62) begin
        // next data frame of the current burst from the far end
        send_rx_frame(KIND_DATA, seq_t'(peer_base + burst_order[burst_pos]), fair_ack(),
                      $urandom);
        burst_pos++;
        if (burst_pos == NR_BUFS) begin
          peer_base = peer_base + seq_t'(NR_BUFS);
          burst_pos = 0;
          shuffle_burst();
        end
      end else if (r < 72) begin
        send_rx_frame(KIND_ACK, seq_t'($urandom), fair_ack(), $urandom);
      end else if (r < 78) begin
        send_rx_frame(KIND_NAK, seq_t'($urandom), fair_ack(), $urandom);
      end else if (r < 83) begin
        send_op(OP_CKSUM_ERR);
      end else if (r < 88) begin
        // only slots that already hold a packet may time out
        if (slot_written != '0) begin
          do sq = seq_t'($urandom_range(0, 7)); while (!slot_written[sq % NR_BUFS]);
          send_timeout(sq);
        end
      end else if (r < 92) begin
        send_op(OP_ACK_TIMEOUT);
      end else if (r < 98) begin
        // line noise: any kind, any sequence numbers
        send_rx_frame(2'($urandom_range(0, 3)), seq_t'($urandom), seq_t'($urandom),
                      $urandom);
      end else begin
        send_op(OP_RSVD_LO + 3'($urandom_range(0, 2)));
      end
    end
    start <= 1'b0;

    // drain: every expected result in, then a few more cycles to catch extras
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // watchdog: a correct run needs a small fraction of this
  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sra_pkg.sv
rtl/core/sra_datapath.sv
rtl/core/sra_ctrl.sv
rtl/core/selective_repeat_arq_top.sv
rtl/core/sra_checker.sv
tb/arq_checker.sv
tb/testbench.sv
